// File: hdl/psa_pkg.sv
// shared types, constants and residue helpers for the atkin sieve block
// no dependencies
`default_nettype none

package psa_pkg;

  localparam int MAX_BOUND_DEF = 65535;
  localparam int VAL_MAX       = 65535;

  localparam int VAL_W = 16;  // query values, limit, store addresses
  localparam int CNT_W = 9;   // x, y and r counters
  localparam int SQ_W  = 17;  // squares and multiple pointer
  localparam int N_W   = 19;  // quadratic form values

  localparam logic [VAL_W-1:0] BOUND_RESET = 16'hFFFF;
  localparam logic [VAL_W-1:0] PRIME_TWO   = 16'd2;
  localparam logic [VAL_W-1:0] PRIME_THREE = 16'd3;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // residues mod 12 selecting each quadratic form
  localparam logic [3:0] RES_A_LO = 4'd1;
  localparam logic [3:0] RES_A_HI = 4'd5;
  localparam logic [3:0] RES_B    = 4'd7;
  localparam logic [3:0] RES_C    = 4'd11;
  localparam logic [3:0] M12_LAST = 4'd11;
  localparam logic [5:0] MOD_BASE = 6'd12;

  typedef struct packed {
    logic             operation;
    logic [VAL_W-1:0] query_value;
  } psa_in_t;

  typedef struct packed {
    logic is_prime;
    logic out_of_range;
  } psa_out_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             wr_data;
    logic [VAL_W-1:0] addr;
  } psa_mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } psa_seq_stat_t;

  // square of a residue, reduced mod 12
  function automatic logic [3:0] sq_mod12(input logic [3:0] v);
    logic [3:0] r;
    unique case (v)
      4'd0, 4'd6:                r = 4'd0;
      4'd1, 4'd5, 4'd7, 4'd11:   r = 4'd1;
      4'd2, 4'd4, 4'd8, 4'd10:   r = 4'd4;
      4'd3, 4'd9:                r = 4'd9;
      default:                   r = 4'd0;
    endcase
    return r;
  endfunction

  // reduce a small sum (below 60) mod 12
  function automatic logic [3:0] mod12(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    for (int i = 0; i < 4; i++) begin
      if (t >= MOD_BASE) t = t - MOD_BASE;
    end
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/psa_store.sv
// one-bit-per-number mark store, single port, registered read
// depends on psa_pkg
`default_nettype none

module psa_store
  import psa_pkg::*;
#(
  parameter int DEPTH = MAX_BOUND_DEF + 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic          wr_en,
  input  logic          wr_data,
  input  logic [AW-1:0] addr,
  output logic          rd_data
);

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/psa_seq.sv
// build sequencer: clear sweep, quadratic-form toggles, square-free cull
// depends on psa_pkg; drives the store through a psa_mem_req_t
`default_nettype none

module psa_seq
  import psa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             done_ack,
  input  logic [VAL_W-1:0] lim,
  input  logic             rd_data,
  output psa_mem_req_t     mem_req,
  output psa_seq_stat_t    stat
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CLEAR    = 3'd1;
  localparam logic [2:0] ST_FORM     = 3'd2;
  localparam logic [2:0] ST_TOGGLE   = 3'd3;
  localparam logic [2:0] ST_CULL_RD  = 3'd4;
  localparam logic [2:0] ST_CULL_TST = 3'd5;
  localparam logic [2:0] ST_CULL_WR  = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  localparam logic [1:0] FORM_A = 2'd0;  // 4x^2 + y^2
  localparam logic [1:0] FORM_B = 2'd1;  // 3x^2 + y^2
  localparam logic [1:0] FORM_C = 2'd2;  // 3x^2 - y^2

  localparam logic [CNT_W-1:0] CULL_FIRST    = 9'd5;
  localparam logic [SQ_W-1:0]  CULL_FIRST_SQ = 17'd25;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       form_r, form_nxt;
  logic [CNT_W-1:0] outer_r, outer_nxt;
  logic [SQ_W-1:0]  outer_sq_r, outer_sq_nxt;
  logic [N_W-1:0]   outer_sq3_r, outer_sq3_nxt;
  logic [3:0]       outer_m12_r, outer_m12_nxt;
  logic [CNT_W-1:0] inner_r, inner_nxt;
  logic [SQ_W-1:0]  inner_sq_r, inner_sq_nxt;
  logic [3:0]       inner_m12_r, inner_m12_nxt;
  logic [SQ_W-1:0]  mult_r, mult_nxt;
  logic [VAL_W-1:0] addr_r, addr_nxt;

  logic [N_W-1:0]   lim_n;
  logic [SQ_W-1:0]  lim_s;
  logic [N_W-1:0]   n_a, n_b, n_c, form_n;
  logic [3:0]       sx, sy, res_a, res_b, res_c;
  logic             form_hit;
  logic [CNT_W:0]   inner_step, outer_step;
  logic [SQ_W-1:0]  inner_sq_inc, outer_sq_inc, mult_inc;
  logic [N_W-1:0]   outer_sq3_inc;
  logic             inner_end, outer_end;
  logic             step_done;

  assign lim_n = N_W'(lim);
  assign lim_s = SQ_W'(lim);

  assign n_a = {outer_sq_r, 2'b00} + N_W'(inner_sq_r);
  assign n_b = outer_sq3_r + N_W'(inner_sq_r);
  assign n_c = outer_sq3_r - N_W'(inner_sq_r);

  assign sx    = sq_mod12(outer_m12_r);
  assign sy    = sq_mod12(inner_m12_r);
  assign res_a = mod12(6'({sx, 2'b00}) + 6'(sy));
  assign res_b = mod12(6'({sx, 1'b0}) + 6'(sx) + 6'(sy));
  assign res_c = mod12(6'({sx, 1'b0}) + 6'(sx) + MOD_BASE - 6'(sy));

  always_comb begin
    case (form_r)
      FORM_A: begin
        form_n   = n_a;
        form_hit = (n_a <= lim_n) && ((res_a == RES_A_LO) || (res_a == RES_A_HI));
      end
      FORM_B: begin
        form_n   = n_b;
        form_hit = (n_b <= lim_n) && (res_b == RES_B);
      end
      FORM_C: begin
        form_n   = n_c;
        form_hit = (outer_r > inner_r) && (n_c <= lim_n) && (res_c == RES_C);
      end
      default: begin
        form_n   = n_a;
        form_hit = 1'b0;
      end
    endcase
  end

  // next square from the current root: (k+1)^2 = k^2 + 2k + 1
  assign inner_step    = {inner_r, 1'b1};
  assign outer_step    = {outer_r, 1'b1};
  assign inner_sq_inc  = inner_sq_r + SQ_W'(inner_step);
  assign outer_sq_inc  = outer_sq_r + SQ_W'(outer_step);
  assign outer_sq3_inc = outer_sq3_r + N_W'(outer_step) + N_W'({outer_step, 1'b0});
  assign inner_end     = inner_sq_inc > lim_s;
  assign outer_end     = outer_sq_inc > lim_s;
  assign mult_inc      = mult_r + outer_sq_r;

  always_comb begin
    state_nxt     = state_r;
    form_nxt      = form_r;
    outer_nxt     = outer_r;
    outer_sq_nxt  = outer_sq_r;
    outer_sq3_nxt = outer_sq3_r;
    outer_m12_nxt = outer_m12_r;
    inner_nxt     = inner_r;
    inner_sq_nxt  = inner_sq_r;
    inner_m12_nxt = inner_m12_r;
    mult_nxt      = mult_r;
    addr_nxt      = addr_r;
    step_done     = 1'b0;
    mem_req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CLEAR;
          mult_nxt  = '0;
        end
      end
      ST_CLEAR: begin
        mem_req.wr_en = 1'b1;
        mem_req.addr  = mult_r[VAL_W-1:0];
        if (mult_r == lim_s) begin
          state_nxt     = ST_FORM;
          form_nxt      = FORM_A;
          outer_nxt     = CNT_W'(1);
          outer_sq_nxt  = SQ_W'(1);
          outer_sq3_nxt = N_W'(3);
          outer_m12_nxt = 4'd1;
          inner_nxt     = CNT_W'(1);
          inner_sq_nxt  = SQ_W'(1);
          inner_m12_nxt = 4'd1;
        end else begin
          mult_nxt = mult_r + SQ_W'(1);
        end
      end
      ST_FORM: begin
        if (form_hit) begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = form_n[VAL_W-1:0];
          addr_nxt      = form_n[VAL_W-1:0];
          state_nxt     = ST_TOGGLE;
        end else begin
          step_done = 1'b1;
        end
      end
      ST_TOGGLE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_data = ~rd_data;
        mem_req.addr    = addr_r;
        state_nxt       = ST_FORM;
        step_done       = 1'b1;
      end
      ST_CULL_RD: begin
        if (outer_sq_r > lim_s) begin
          state_nxt = ST_DONE;
        end else begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = VAL_W'(outer_r);
          state_nxt     = ST_CULL_TST;
        end
      end
      ST_CULL_TST: begin
        if (rd_data) begin
          mult_nxt  = outer_sq_r;
          state_nxt = ST_CULL_WR;
        end else begin
          outer_nxt    = outer_r + CNT_W'(1);
          outer_sq_nxt = outer_sq_inc;
          state_nxt    = ST_CULL_RD;
        end
      end
      ST_CULL_WR: begin
        if (mult_r <= lim_s) begin
          mem_req.wr_en = 1'b1;
          mem_req.addr  = mult_r[VAL_W-1:0];
          mult_nxt      = mult_inc;
        end else begin
          outer_nxt    = outer_r + CNT_W'(1);
          outer_sq_nxt = outer_sq_inc;
          state_nxt    = ST_CULL_RD;
        end
      end
      ST_DONE: begin
        if (done_ack) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // advance form, then y, then x
    if (step_done) begin
      if (form_r != FORM_C) begin
        form_nxt = form_r + 2'd1;
      end else begin
        form_nxt = FORM_A;
        if (!inner_end) begin
          inner_nxt     = inner_r + CNT_W'(1);
          inner_sq_nxt  = inner_sq_inc;
          inner_m12_nxt = (inner_m12_r == M12_LAST) ? 4'd0 : inner_m12_r + 4'd1;
        end else begin
          inner_nxt     = CNT_W'(1);
          inner_sq_nxt  = SQ_W'(1);
          inner_m12_nxt = 4'd1;
          if (outer_end) begin
            state_nxt    = ST_CULL_RD;
            outer_nxt    = CULL_FIRST;
            outer_sq_nxt = CULL_FIRST_SQ;
          end else begin
            outer_nxt     = outer_r + CNT_W'(1);
            outer_sq_nxt  = outer_sq_inc;
            outer_sq3_nxt = outer_sq3_inc;
            outer_m12_nxt = (outer_m12_r == M12_LAST) ? 4'd0 : outer_m12_r + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      form_r      <= FORM_A;
      outer_r     <= '0;
      outer_sq_r  <= '0;
      outer_sq3_r <= '0;
      outer_m12_r <= '0;
      inner_r     <= '0;
      inner_sq_r  <= '0;
      inner_m12_r <= '0;
      mult_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      form_r      <= form_nxt;
      outer_r     <= outer_nxt;
      outer_sq_r  <= outer_sq_nxt;
      outer_sq3_r <= outer_sq3_nxt;
      outer_m12_r <= outer_m12_nxt;
      inner_r     <= inner_nxt;
      inner_sq_r  <= inner_sq_nxt;
      inner_m12_r <= inner_m12_nxt;
      mult_r      <= mult_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  assign stat.busy = (state_r != ST_IDLE);
  assign stat.done = (state_r == ST_DONE);

endmodule

`default_nettype wire

// File: hdl/prime_sieve_atkin_top.sv
// query: accepted one per cycle when the result path flows, result registered in s1 and
//   then in the output register; build: blocks input while clearing marks 0 to L, then
//   toggles each form hit per (x,y) pair with x^2,y^2 <= L, then clears multiples of r^2
//   for each marked root r; all of it is bound by the single port of the mark store
// reset: control clears at once; the store is left as is, a built flag hides it until
//   the first build and reset does no sweep
`default_nettype none

module prime_sieve_atkin_top
  import psa_pkg::*;
#(
  parameter int MAX_BOUND = MAX_BOUND_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  psa_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output psa_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data
);

  localparam int DEPTH = MAX_BOUND + 1;
  localparam int AW    = $clog2(DEPTH);

  // largest limit the store and the value field can both hold
  localparam logic [VAL_W:0] MAX_CAP = (MAX_BOUND > VAL_MAX) ? (VAL_W+1)'(VAL_MAX)
                                                              : (VAL_W+1)'(MAX_BOUND);

  logic [VAL_W-1:0] cfg_bound_r;
  logic [VAL_W-1:0] lim;

  logic             built_r;
  logic [VAL_W-1:0] built_lim_r;

  // query in flight while its mark is read
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_oor_r;
  logic             s1_small_r;
  logic             s1_use_mem_r;

  logic             out_valid_r, out_valid_nxt;
  psa_out_t         out_data_r, out_data_nxt;

  psa_mem_req_t     seq_req, mem_req;
  psa_seq_stat_t    stat;
  logic             rd_data;

  logic             out_free, s1_move, build_fin;
  logic             in_accept, query_acc, build_acc;
  logic             q_in_range;

  // effective limit
  assign lim = ({1'b0, cfg_bound_r} > MAX_CAP) ? MAX_CAP[VAL_W-1:0] : cfg_bound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bound_r <= BOUND_RESET;
    end else if (cfg_wr_en) begin
      cfg_bound_r <= cfg_wr_data;
    end
  end

  // handshake: s1 drains into the output register whenever that register is free
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_free;
  assign build_fin = stat.done && out_free;
  assign in_stall  = stat.busy || (s1_valid_r && !s1_move);
  assign in_accept = in_valid && !in_stall;
  assign query_acc = in_accept && (in_data.operation == OP_QUERY);
  assign build_acc = in_accept && (in_data.operation == OP_BUILD);

  assign q_in_range = in_data.query_value <= lim;

  // the store belongs to the sequencer during a build, to queries otherwise
  always_comb begin
    if (stat.busy) begin
      mem_req = seq_req;
    end else begin
      mem_req         = '0;
      mem_req.rd_en   = query_acc;
      mem_req.addr    = in_data.query_value;
    end
  end

  psa_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (mem_req.rd_en),
    .wr_en   (mem_req.wr_en),
    .wr_data (mem_req.wr_data),
    .addr    (AW'(mem_req.addr)),
    .rd_data (rd_data)
  );

  psa_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (build_acc),
    .done_ack (build_fin),
    .lim      (lim),
    .rd_data  (rd_data),
    .mem_req  (seq_req),
    .stat     (stat)
  );

  // built flag and the limit of the last build; 2 and 3 read as prime after any build,
  // marks above the last build's limit read as cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      built_r <= 1'b0;
    end else if (build_acc) begin
      built_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (build_acc) built_lim_r <= lim;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (query_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      s1_oor_r     <= !q_in_range;
      s1_small_r   <= built_r && q_in_range &&
                      ((in_data.query_value == PRIME_TWO) ||
                       (in_data.query_value == PRIME_THREE));
      s1_use_mem_r <= built_r && q_in_range && (in_data.query_value <= built_lim_r);
    end
  end

  // output register: query results from s1, the build transaction's zero result
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_move) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_of_range = s1_oor_r;
      out_data_nxt.is_prime     = !s1_oor_r && (s1_small_r || (s1_use_mem_r && rd_data));
    end else if (build_fin) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> !mem_req.wr_en)
    else $error("store written outside a build");

  a_build_starts: assert property (@(posedge clk) disable iff (!rst_n)
    build_acc |=> stat.busy)
    else $error("build transaction did not start the sequencer");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> !s1_valid_r)
    else $error("build finished with a query still in flight");

  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |-> !out_data.is_prime)
    else $error("out of range result flagged prime");
`endif

endmodule

`default_nettype wire
